// File: rtl/disc_junk_data_generator_defines.svh
// Assertion macros shared by the junk data generator RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef DISC_JUNK_DATA_GENERATOR_DEFINES_SVH
`define DISC_JUNK_DATA_GENERATOR_DEFINES_SVH

// A property checked at every clock edge outside of reset.
`define DJDG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("djdg assertion failed");

// A condition that must never be seen outside of reset.
`define DJDG_NEVER(lbl, cond) `DJDG_ASSERT(lbl, !(cond))

`endif

// File: rtl/djdg_pkg.sv
// Package for the junk data generator: constants, codes and command struct.
// No dependencies.
package djdg_pkg;

    localparam int TABLE_DEPTH    = 521;
    localparam int SHORT_LAG      = 32;
    localparam int SEED_WORDS     = 17;
    localparam int WORDS_PER_SEED = 8192;
    localparam int BLOCK_WORDS    = 65536;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int SEED_LOG       = $clog2(WORDS_PER_SEED);

    localparam logic [31:0] SEED_MUL   = 32'h5d588b65;
    localparam logic [31:0] BLOCK_STEP = 32'h1ef29123;
    localparam logic [31:0] ID_MUL     = 32'h0260bcd5;

    // Configuration register indexes.
    localparam logic CFG_DISC_ID     = 1'b0;
    localparam logic CFG_DISC_NUMBER = 1'b1;

    // Shared multiplier operand selection.
    typedef logic [1:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE = 2'd0;
    localparam t_mul_sel MUL_BLK  = 2'd1;
    localparam t_mul_sel MUL_ID   = 2'd2;

    // Table write data selection.
    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_ACC = 2'd0;
    localparam t_wr_sel WR_EXT = 2'd1;
    localparam t_wr_sel WR_XOR = 2'd2;

    typedef struct packed {
        logic              blk_ld;
        t_mul_sel          mul_sel;
        logic              rbs_ld_prod;
        logic              rbs_add_step;
        logic              s_ld_seed;
        logic              gen_step;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wr_sel           wr_sel;
        logic              out_ld;
        logic              out_last;
    } t_dp_cmd;

endpackage

// File: rtl/djdg_in_if.sv
// Input channel interface of the junk data generator.
// Depends on nothing.
interface djdg_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] block_number;

    modport source (output valid, output command, output block_number, input ready);
    modport sink (input valid, input command, input block_number, output ready);
endinterface

// File: rtl/djdg_out_if.sv
// Output channel interface of the junk data generator.
// Depends on nothing.
interface djdg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] junk_word;
    logic        last_word;

    modport source (output valid, output junk_word, output last_word, input ready);
    modport sink (input valid, input junk_word, input last_word, output ready);
endinterface

// File: rtl/djdg_dp.sv
// Datapath: lag table memory, multipliers, seed generator and output register.
// Depends on djdg_pkg.
module djdg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_command,
    input  logic [31:0]       i_block_number,
    input  djdg_pkg::t_dp_cmd i_cmd,
    output logic [31:0]       o_junk_word,
    output logic              o_last_word
);
    import djdg_pkg::*;

    logic [31:0] r_lag [TABLE_DEPTH];
    logic [31:0] r_rd0, r_rd1;
    logic [31:0] r_disc_id;
    logic [7:0]  r_disc_num;
    logic [31:0] r_blk, r_prod, r_rbs, r_s, r_acc, r_prev;
    logic [31:0] r_word;
    logic        r_last;

    logic [8:0]  sum_lo, sum_hi;
    logic [31:0] id_mix;
    logic [31:0] mul_a, mul_b;
    logic [31:0] n_s, n_acc, ext_word, wr_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_id  <= '0;
            r_disc_num <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DISC_ID:     r_disc_id  <= i_cfg_data;
                CFG_DISC_NUMBER: r_disc_num <= i_cfg_data[7:0];
                default:         r_disc_id  <= r_disc_id;
            endcase
        end
    end

    // Disc seed mix; byte sums carry into the next byte as the scheme does.
    assign sum_lo = {1'b0, r_disc_id[7:0]} + {1'b0, r_disc_id[15:8]};
    assign sum_hi = {1'b0, r_disc_id[31:24]} + {1'b0, r_disc_id[23:16]};
    assign id_mix = ({r_disc_id[23:16], r_disc_id[15:8], 16'h0000}
                   | {15'd0, sum_hi, 8'h00} | {23'd0, sum_lo})
                   ^ {24'd0, r_disc_num};

    // Multiplier for the block seed and the disc seed.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_BLK: begin
                mul_a = {r_blk[28:0], 3'b000};
                mul_b = BLOCK_STEP;
            end
            MUL_ID: begin
                mul_a = id_mix;
                mul_b = ID_MUL;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Generator step: one multiplicative update per cycle while gen_step is set, top bit shifted in.
    assign n_s   = 32'(r_s * SEED_MUL) + 32'd1;
    assign n_acc = {n_s[31], r_acc[31:1]};

    assign ext_word = (r_rd0 << 23) ^ (r_rd1 >> 9) ^ r_prev;

    always_comb begin
        case (i_cmd.wr_sel)
            WR_ACC:  wr_data = n_acc;
            WR_EXT:  wr_data = ext_word;
            WR_XOR:  wr_data = r_rd0 ^ r_rd1;
            default: wr_data = r_rd0;
        endcase
    end

    // Seed and generator registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_ld) begin
            r_blk <= i_command ? 32'd0 : i_block_number;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= 32'(mul_a * mul_b);
        end
        if (i_cmd.rbs_ld_prod) begin
            r_rbs <= r_prod;
        end else if (i_cmd.rbs_add_step) begin
            r_rbs <= r_rbs + BLOCK_STEP;
        end
        if (i_cmd.s_ld_seed) begin
            r_s <= r_prod ^ r_rbs;
        end else if (i_cmd.gen_step) begin
            r_s   <= n_s;
            r_acc <= n_acc;
        end
        if (i_cmd.wr_en) begin
            r_prev <= wr_data;
        end
    end

    // Lag table: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_lag[i_cmd.wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd0 <= r_lag[i_cmd.rd_addr0];
            r_rd1 <= r_lag[i_cmd.rd_addr1];
        end
    end

    // Output register with the byte packing of the scheme.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_word <= {r_rd0[31:24], r_rd0[25:18], r_rd0[15:8], r_rd0[7:0]};
            r_last <= i_cmd.out_last;
        end
    end

    assign o_junk_word = r_word;
    assign o_last_word = r_last;

endmodule

// File: rtl/djdg_ctrl.sv
// Controller state machine: sequences seeding, XOR passes and word reads.
// Depends on djdg_pkg and the assertion macro header.
`include "disc_junk_data_generator_defines.svh"
module djdg_ctrl #(
    parameter int BLOCK_WORDS = djdg_pkg::BLOCK_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output djdg_pkg::t_dp_cmd o_cmd
);
    import djdg_pkg::*;

    localparam int WIB_W = $clog2(BLOCK_WORDS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_BLKW  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_IDW   = 4'd4;
    localparam logic [3:0] S_GEN   = 4'd5;
    localparam logic [3:0] S_EXTR  = 4'd6;
    localparam logic [3:0] S_EXTW  = 4'd7;
    localparam logic [3:0] S_PASSR = 4'd8;
    localparam logic [3:0] S_PASSW = 4'd9;
    localparam logic [3:0] S_STEP  = 4'd10;
    localparam logic [3:0] S_RD    = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] SEED_LAST = ADDR_W'(SEED_WORDS - 1);
    localparam logic [ADDR_W-1:0] LAG_FAR   = ADDR_W'(TABLE_DEPTH - SHORT_LAG);
    localparam logic [ADDR_W-1:0] LAG_NEAR  = ADDR_W'(SHORT_LAG);
    localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
    localparam logic [WIB_W-1:0]  WIB_LAST  = WIB_W'(BLOCK_WORDS - 1);
    localparam logic [WIB_W-1:0]  WIB_ONE   = WIB_W'(1);

    logic [3:0]        r_state, n_state;
    logic              r_start, n_start;
    logic              r_started, n_started;
    logic [WIB_W-1:0]  r_wib, n_wib;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [4:0]        r_bit, n_bit;
    logic [1:0]        r_npass, n_npass;
    logic              r_seeding, n_seeding;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    // Next-state and command logic.
    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_started   = r_started;
        n_wib       = r_wib;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_bit       = r_bit;
        n_npass     = r_npass;
        n_seeding   = r_seeding;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.wr_sel  = WR_ACC;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.blk_ld = 1'b1;
                    n_start      = !i_command || !r_started;
                    n_state      = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (r_start) begin
                    o_cmd.mul_sel = MUL_BLK;
                    n_state       = S_BLKW;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_BLKW: begin
                o_cmd.rbs_ld_prod = 1'b1;
                n_wib             = '0;
                n_started         = 1'b1;
                n_state           = S_CHK;
            end
            S_CHK: begin
                if (r_wib[SEED_LOG-1:0] == '0) begin
                    o_cmd.mul_sel = MUL_ID;
                    n_state       = S_IDW;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_IDW: begin
                o_cmd.s_ld_seed    = 1'b1;
                o_cmd.rbs_add_step = 1'b1;
                n_idx              = '0;
                n_bit              = '0;
                n_state            = S_GEN;
            end
            // Thirty-two generator steps build each of the first seed words.
            S_GEN: begin
                o_cmd.gen_step = 1'b1;
                n_bit          = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_idx;
                    o_cmd.wr_sel  = WR_ACC;
                    if (r_idx == SEED_LAST) begin
                        n_state = S_EXTR;
                    end else begin
                        n_idx = r_idx + ADDR_ONE;
                    end
                end
            end
            // Extension; the last seed word first folds in word zero.
            S_EXTR: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr0 = (r_idx == SEED_LAST) ? SEED_LAST
                                                      : r_idx - ADDR_W'(SEED_WORDS);
                o_cmd.rd_addr1 = r_idx - SEED_LAST;
                n_state        = S_EXTW;
            end
            S_EXTW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_idx;
                o_cmd.wr_sel  = WR_EXT;
                if (r_idx == LAST_IDX) begin
                    n_idx     = '0;
                    n_npass   = 2'd3;
                    n_seeding = 1'b1;
                    n_state   = S_PASSR;
                end else begin
                    n_idx   = r_idx + ADDR_ONE;
                    n_state = S_EXTR;
                end
            end
            // In-place forward XOR pass; each entry is read in S_PASSR and written in S_PASSW.
            S_PASSR: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr0 = r_idx;
                o_cmd.rd_addr1 = (r_idx < LAG_NEAR) ? r_idx + LAG_FAR : r_idx - LAG_NEAR;
                n_state        = S_PASSW;
            end
            S_PASSW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_idx;
                o_cmd.wr_sel  = WR_XOR;
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    if (r_npass != 2'd1) begin
                        n_npass = r_npass - 2'd1;
                        n_state = S_PASSR;
                    end else if (r_seeding) begin
                        n_seeding = 1'b0;
                        n_pos     = LAST_IDX;
                        n_state   = S_STEP;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    n_idx   = r_idx + ADDR_ONE;
                    n_state = S_PASSR;
                end
            end
            S_STEP: begin
                if (r_pos == LAST_IDX) begin
                    n_pos   = '0;
                    n_idx   = '0;
                    n_npass = 2'd1;
                    n_state = S_PASSR;
                end else begin
                    n_pos   = r_pos + ADDR_ONE;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr0 = r_pos;
                o_cmd.rd_addr1 = r_pos;
                n_state        = S_OUT;
            end
            // Hand the word to the output register once it is free.
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = (r_wib == WIB_LAST);
                    n_out_valid    = 1'b1;
                    n_wib          = (r_wib == WIB_LAST) ? '0 : r_wib + WIB_ONE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_started   <= 1'b0;
            r_wib       <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_bit       <= '0;
            r_npass     <= '0;
            r_seeding   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_started   <= n_started;
            r_wib       <= n_wib;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_bit       <= n_bit;
            r_npass     <= n_npass;
            r_seeding   <= n_seeding;
            r_out_valid <= n_out_valid;
        end
    end

    `DJDG_NEVER(a_pos_range, r_pos > LAST_IDX)
    `DJDG_NEVER(a_idx_range, r_idx > LAST_IDX)
    `DJDG_NEVER(a_pass_count, (r_state == S_PASSR || r_state == S_PASSW) && r_npass == 2'd0)
    `DJDG_ASSERT(a_accept_leaves_idle, accept |=> r_state == S_BEGIN)
    `DJDG_NEVER(a_first_is_start, r_state == S_BEGIN && !r_started && !r_start)

endmodule

// File: rtl/disc_junk_data_generator.sv
// A plain word is read from the table into the output register; when the 521-word
// table is used up, an in-place XOR pass over it runs first. A start, and a next at
// the 8192-word reseed, first seed the table (544 generator steps, then extension
// and four XOR passes). One item at a time; the next is taken while the result waits.
// Reset: synchronous active low; clears control, counters and config registers.
// Top level: joins the controller and datapath to the channel interfaces.
// Depends on djdg_pkg, djdg_in_if, djdg_out_if, djdg_ctrl and djdg_dp.
module disc_junk_data_generator #(
    parameter int BLOCK_WORDS = djdg_pkg::BLOCK_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    djdg_in_if.sink     i_in,
    djdg_out_if.source  o_out
);
    import djdg_pkg::*;

    t_dp_cmd dp_cmd;

    // Sequencer.
    djdg_ctrl #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd)
    );

    // Table and arithmetic.
    djdg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_in.command),
        .i_block_number (i_in.block_number),
        .i_cmd          (dp_cmd),
        .o_junk_word    (o_out.junk_word),
        .o_last_word    (o_out.last_word)
    );

endmodule
